>>> rtl/core/tco_pkg.sv
// Package for the triangle / cube overlap test: widths, reset value, types.
// Used by the channel interfaces and the pipeline top level.
`default_nettype none
package tco_pkg;
	localparam int CoordWidth = 24;
	localparam int SizeWidth = 23;
	localparam logic [SizeWidth-1:0] SizeReset = 23'd4096;
	// Relative vertices and edges need one and two more bits.
	localparam int RelWidth = CoordWidth + 1;
	localparam int EdgeWidth = CoordWidth + 2;
	localparam int ProdWidth = 2 * EdgeWidth + 2;
	localparam int NormWidth = 2 * EdgeWidth + 1;
	localparam int DotWidth = NormWidth + RelWidth + 5;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [RelWidth-1:0] rel_t;
	typedef logic signed [EdgeWidth-1:0] edge_t;

	typedef struct packed {
		coord_t v0_x, v0_y, v0_z;
		coord_t v1_x, v1_y, v1_z;
		coord_t v2_x, v2_y, v2_z;
		coord_t center_x, center_y, center_z;
	} tri_word_t;

	typedef struct packed {
		logic overlap;
	} res_word_t;
endpackage
`default_nettype wire

>>> rtl/core/tco_chan_if.sv
// Valid/ready channel interfaces for input, result and configuration words.
// Depends on tco_pkg.
`default_nettype none
interface tco_tri_if;
	logic valid;
	logic ready;
	tco_pkg::tri_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tco_res_if;
	logic valid;
	logic ready;
	tco_pkg::res_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tco_cfg_if;
	logic valid;
	logic ready;
	logic [tco_pkg::SizeWidth-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/triangle_cube_overlap_test.sv
// Top level of the triangle / axis-aligned cube overlap test pipeline.
// Depends on tco_pkg and the channel interfaces in tco_chan_if.sv.
`default_nettype none
// One word enters per clock while the pipeline advances, and its overlap flag
// leaves through the six pipeline stages (relative vertices, edges and box test,
// edge products and plane normal, axis compares and split plane products, plane
// dot terms, final sum and compares). The pipeline stalls as a whole when a
// result is held and not taken; no word is lost or repeated. The configuration word
// sets the cube edge length and is taken at any time, but should be written
// only while the pipeline is empty.
module triangle_cube_overlap_test (
	input wire clk,
	input wire arst_n,
	tco_tri_if.sink tri_in,
	tco_res_if.source res_out,
	tco_cfg_if.sink cfg
);
	import tco_pkg::*;

	localparam int PW = ProdWidth + SizeWidth + 4;
	// The plane normal is split in two halves so each product stays narrow.
	localparam int NLoWidth = EdgeWidth;
	localparam int NHiWidth = NormWidth - NLoWidth;
	localparam int OpWidth = RelWidth + 3;
	localparam int PartWidth = NHiWidth + OpWidth;

	logic [SizeWidth-1:0] size_q;
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic ovl_s6;

	// Whole pipeline moves whenever the output slot is free or taken.
	assign adv = !vld_s6 || res_out.ready;
	assign tri_in.ready = adv;
	assign cfg.ready = 1'b1;
	assign res_out.valid = vld_s6;
	assign res_out.data.overlap = ovl_s6;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SizeReset;
		end else if (cfg.valid) begin
			size_q <= cfg.data;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= tri_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 1: vertices relative to the cube center.
	rel_t v_s1 [3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1[0][0] <= RelWidth'(tri_in.data.v0_x) - RelWidth'(tri_in.data.center_x);
			v_s1[0][1] <= RelWidth'(tri_in.data.v0_y) - RelWidth'(tri_in.data.center_y);
			v_s1[0][2] <= RelWidth'(tri_in.data.v0_z) - RelWidth'(tri_in.data.center_z);
			v_s1[1][0] <= RelWidth'(tri_in.data.v1_x) - RelWidth'(tri_in.data.center_x);
			v_s1[1][1] <= RelWidth'(tri_in.data.v1_y) - RelWidth'(tri_in.data.center_y);
			v_s1[1][2] <= RelWidth'(tri_in.data.v1_z) - RelWidth'(tri_in.data.center_z);
			v_s1[2][0] <= RelWidth'(tri_in.data.v2_x) - RelWidth'(tri_in.data.center_x);
			v_s1[2][1] <= RelWidth'(tri_in.data.v2_y) - RelWidth'(tri_in.data.center_y);
			v_s1[2][2] <= RelWidth'(tri_in.data.v2_z) - RelWidth'(tri_in.data.center_z);
		end
	end

	// Stage 2: edges, per-axis box test and edge radius sums.
	edge_t e_s2 [3][3];
	rel_t v_s2 [3][3];
	logic box_sep_s2;
	logic [EdgeWidth:0] esum_s2 [3][3];
	edge_t e_c [3][3];
	logic box_c;
	always_comb begin
		rel_t lo, hi;
		box_c = 1'b0;
		for (int a = 0; a < 3; a++) begin
			e_c[0][a] = EdgeWidth'(v_s1[1][a]) - EdgeWidth'(v_s1[0][a]);
			e_c[1][a] = EdgeWidth'(v_s1[2][a]) - EdgeWidth'(v_s1[1][a]);
			e_c[2][a] = EdgeWidth'(v_s1[0][a]) - EdgeWidth'(v_s1[2][a]);
			lo = v_s1[0][a];
			hi = v_s1[0][a];
			for (int k = 1; k < 3; k++) begin
				if (v_s1[k][a] < lo) lo = v_s1[k][a];
				if (v_s1[k][a] > hi) hi = v_s1[k][a];
			end
			if (((EdgeWidth+1)'(lo) <<< 1) > $signed((EdgeWidth+1)'({1'b0, size_q}))
					|| ((EdgeWidth+1)'(hi) <<< 1)
					< -$signed((EdgeWidth+1)'({1'b0, size_q})))
				box_c = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s2 <= e_c;
			v_s2 <= v_s1;
			box_sep_s2 <= box_c;
			for (int k = 0; k < 3; k++)
				for (int a = 0; a < 3; a++)
					esum_s2[k][a] <=
						(EdgeWidth+1)'(e_c[k][(a+1)%3] < 0 ? -e_c[k][(a+1)%3]
							: e_c[k][(a+1)%3])
						+ (EdgeWidth+1)'(e_c[k][(a+2)%3] < 0 ? -e_c[k][(a+2)%3]
							: e_c[k][(a+2)%3]);
		end
	end

	// Stage 3: projection products, radii and the plane normal.
	localparam int PairI [3][3] = '{'{0, 0, 1}, '{0, 0, 0}, '{0, 0, 1}};
	localparam int PairJ [3][3] = '{'{2, 2, 2}, '{2, 2, 1}, '{1, 1, 2}};
	logic signed [PW-1:0] pi_s3 [3][3];
	logic signed [PW-1:0] pj_s3 [3][3];
	logic signed [PW-1:0] rad_s3 [3][3];
	logic signed [NormWidth-1:0] n_s3 [3];
	rel_t v0_s3 [3];
	logic box_sep_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int a = 0; a < 3; a++) begin
					pi_s3[k][a] <= PW'(e_s2[k][(a+2)%3] * v_s2[PairI[k][a]][(a+1)%3])
						- PW'(e_s2[k][(a+1)%3] * v_s2[PairI[k][a]][(a+2)%3]);
					pj_s3[k][a] <= PW'(e_s2[k][(a+2)%3] * v_s2[PairJ[k][a]][(a+1)%3])
						- PW'(e_s2[k][(a+1)%3] * v_s2[PairJ[k][a]][(a+2)%3]);
					rad_s3[k][a] <= $signed(PW'(esum_s2[k][a] * size_q));
				end
			end
			for (int a = 0; a < 3; a++) begin
				n_s3[a] <= NormWidth'(e_s2[0][(a+1)%3] * e_s2[1][(a+2)%3])
					- NormWidth'(e_s2[0][(a+2)%3] * e_s2[1][(a+1)%3]);
				v0_s3[a] <= v_s2[0][a];
			end
			box_sep_s3 <= box_sep_s2;
		end
	end

	// Stage 4: edge axis compares and the split plane products.
	logic edge_sep_s4;
	logic box_sep_s4;
	logic signed [PartWidth-1:0] hmin_s4 [3];
	logic signed [PartWidth-1:0] lmin_s4 [3];
	logic signed [PartWidth-1:0] hmax_s4 [3];
	logic signed [PartWidth-1:0] lmax_s4 [3];
	logic edge_c;
	logic signed [OpWidth-1:0] omin_c [3];
	logic signed [OpWidth-1:0] omax_c [3];
	logic signed [NHiWidth-1:0] nhi_c [3];
	logic signed [NLoWidth:0] nlo_c [3];
	always_comb begin
		logic signed [PW-1:0] lo, hi;
		edge_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			for (int a = 0; a < 3; a++) begin
				lo = (pj_s3[k][a] < pi_s3[k][a]) ? pj_s3[k][a] : pi_s3[k][a];
				hi = (pj_s3[k][a] < pi_s3[k][a]) ? pi_s3[k][a] : pj_s3[k][a];
				if ((lo <<< 1) > rad_s3[k][a] || (hi <<< 1) < -rad_s3[k][a])
					edge_c = 1'b1;
			end
		end
	end
	// Cube corner offsets picked by the normal's sign, and the normal halves.
	always_comb begin
		logic signed [OpWidth-1:0] sz, lo, hi;
		sz = $signed(OpWidth'({1'b0, size_q}));
		for (int a = 0; a < 3; a++) begin
			lo = -sz - (OpWidth'(v0_s3[a]) <<< 1);
			hi = sz - (OpWidth'(v0_s3[a]) <<< 1);
			omin_c[a] = (n_s3[a] > 0) ? lo : hi;
			omax_c[a] = (n_s3[a] > 0) ? hi : lo;
			nhi_c[a] = $signed(n_s3[a][NormWidth-1:NLoWidth]);
			nlo_c[a] = $signed({1'b0, n_s3[a][NLoWidth-1:0]});
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			edge_sep_s4 <= edge_c;
			box_sep_s4 <= box_sep_s3;
			for (int a = 0; a < 3; a++) begin
				hmin_s4[a] <= PartWidth'(nhi_c[a] * omin_c[a]);
				lmin_s4[a] <= PartWidth'(nlo_c[a] * omin_c[a]);
				hmax_s4[a] <= PartWidth'(nhi_c[a] * omax_c[a]);
				lmax_s4[a] <= PartWidth'(nlo_c[a] * omax_c[a]);
			end
		end
	end

	// Stage 5: plane dot terms from the two halves.
	logic edge_sep_s5;
	logic box_sep_s5;
	logic signed [DotWidth-1:0] tmin_s5 [3];
	logic signed [DotWidth-1:0] tmax_s5 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			edge_sep_s5 <= edge_sep_s4;
			box_sep_s5 <= box_sep_s4;
			for (int a = 0; a < 3; a++) begin
				tmin_s5[a] <= (DotWidth'(hmin_s4[a]) <<< NLoWidth) + DotWidth'(lmin_s4[a]);
				tmax_s5[a] <= (DotWidth'(hmax_s4[a]) <<< NLoWidth) + DotWidth'(lmax_s4[a]);
			end
		end
	end

	// Stage 6: plane test and final flag.
	logic signed [DotWidth-1:0] dmin_c, dmax_c;
	assign dmin_c = tmin_s5[0] + tmin_s5[1] + tmin_s5[2];
	assign dmax_c = tmax_s5[0] + tmax_s5[1] + tmax_s5[2];
	always_ff @(posedge clk) begin
		if (adv) begin
			ovl_s6 <= !(edge_sep_s5 || box_sep_s5 || dmin_c > 0 || dmax_c < 0);
		end
	end

`ifndef SYNTH
	// A held result stays valid until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid)
		else $error("result dropped while stalled");
	// An accepted word shows up at the output when the pipeline is never stalled.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		tri_in.valid && tri_in.ready && res_out.ready ##1 res_out.ready
		##1 res_out.ready ##1 res_out.ready ##1 res_out.ready ##1 res_out.ready
		|=> res_out.valid)
		else $error("pipeline lost a word");
	// Input accepted whenever the output slot frees.
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!res_out.valid |-> tri_in.ready)
		else $error("pipeline stalled with free output");
`endif
endmodule
`default_nettype wire
